>>> hw/rtl/ket_pkg.sv
// Shared types and codes for the keyed entry table.
`timescale 1ns / 1ps
`default_nettype none

package ket_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEL_MISSING = 3'd3;
  localparam logic [STAT_W-1:0] ST_LKP_MISSING = 3'd4;
  localparam logic [STAT_W-1:0] ST_KEY_TAKEN   = 3'd5;
  localparam logic [STAT_W-1:0] ST_UPD_MISSING = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] new_key;
    logic [VALUE_W-1:0]      entry_value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/ket_store.sv
// Key and value memories: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ket_store #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ket_pkg::KEY_W-1:0]   wr_key,
  input  wire logic [ket_pkg::VALUE_W-1:0] wr_value,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [ket_pkg::KEY_W-1:0]   rd_key,
  output logic      [ket_pkg::VALUE_W-1:0] rd_value
);

  logic [ket_pkg::KEY_W-1:0]   key_mem   [DEPTH];
  logic [ket_pkg::VALUE_W-1:0] value_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/keyed_entry_table_core.sv
// Top level of the keyed entry table: sequencer, scan compare and output register.
// One word is taken at a time: in_stall is high from accept until the result word is
// registered. Add, lookup and update scan the table through the one read port; delete
// scans and then, on a hit before the last entry, shifts the later entries down through it.
// Reset (rst_n low, synchronous): count 0, capacity min(64, DEPTH); memory not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyed_entry_table_core #(
  parameter int DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ket_pkg::in_word_t              in_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ket_pkg::out_word_t                  out_word,
  input  wire logic                           cfg_we,
  input  wire logic [ket_pkg::COUNT_W-1:0]    cfg_wdata
);

  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int RESET_CAP = (DEPTH < 64) ? DEPTH : 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [ket_pkg::OP_W-1:0]      op_r;
  logic [ket_pkg::KEY_W-1:0]     key_r;
  logic [ket_pkg::KEY_W-1:0]     nkey_r;
  logic [ket_pkg::VALUE_W-1:0]   val_r;
  logic [CNT_W-1:0]              idx_r;
  logic                          cmp_vld_r;
  logic [IDX_W-1:0]              cmp_idx_r;
  logic                          hit_r;
  logic [IDX_W-1:0]              hit_idx_r;
  logic                          taken_r;
  logic [ket_pkg::VALUE_W-1:0]   found_r;
  logic [ket_pkg::STAT_W-1:0]    status_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              cap_r;
  logic                          out_valid_r;
  ket_pkg::out_word_t            out_word_r;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [ket_pkg::KEY_W-1:0]     mem_wkey;
  logic [ket_pkg::VALUE_W-1:0]   mem_wval;
  logic [ket_pkg::KEY_W-1:0]     mem_rkey;
  logic [ket_pkg::VALUE_W-1:0]   mem_rval;

  logic full;
  logic issue;
  logic add_ok;
  logic upd_ok;

  assign full   = (count_r >= cap_r);
  assign issue  = (idx_r < count_r);
  assign add_ok = (op_r == ket_pkg::OP_ADD) && !full && !hit_r;
  assign upd_ok = (op_r == ket_pkg::OP_UPDATE) && !taken_r && hit_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_idx_r;
    mem_wkey  = nkey_r;
    mem_wval  = val_r;
    if (state_r == S_DECIDE && add_ok) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[IDX_W-1:0];
      mem_wkey  = key_r;
    end else if (state_r == S_DECIDE && upd_ok) begin
      mem_we    = 1'b1;
    end else if (state_r == S_SHIFT && cmp_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = cmp_idx_r;
      mem_wkey  = mem_rkey;
      mem_wval  = mem_rval;
    end
  end

  ket_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_key   (mem_wkey),
    .wr_value (mem_wval),
    .rd_addr  (idx_r[IDX_W-1:0]),
    .rd_key   (mem_rkey),
    .rd_value (mem_rval)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CNT_W'(RESET_CAP);
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      taken_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (32'(cfg_wdata) > DEPTH) begin
          cap_r <= CNT_W'(DEPTH);
        end else begin
          cap_r <= CNT_W'(cfg_wdata);
        end
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_word.opcode;
            key_r     <= in_word.key;
            nkey_r    <= in_word.new_key;
            val_r     <= in_word.entry_value;
            idx_r     <= '0;
            cmp_vld_r <= 1'b0;
            hit_r     <= 1'b0;
            taken_r   <= 1'b0;
            found_r   <= '0;
            unique case (in_word.opcode) inside
              ket_pkg::OP_ADD: begin
                state_r <= full ? S_DECIDE : S_SCAN;
              end
              ket_pkg::OP_DELETE, ket_pkg::OP_LOOKUP, ket_pkg::OP_UPDATE: begin
                state_r <= S_SCAN;
              end
              default: begin
                state_r <= S_DECIDE;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld_r <= issue;
          cmp_idx_r <= idx_r[IDX_W-1:0];
          if (issue) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          if (cmp_vld_r) begin
            if (mem_rkey == key_r && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cmp_idx_r;
              found_r   <= mem_rval;
            end
            if (mem_rkey != key_r && mem_rkey == nkey_r) begin
              taken_r <= 1'b1;
            end
          end
          if (!issue && !cmp_vld_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!(op_r == ket_pkg::OP_LOOKUP && hit_r)) begin
            found_r <= '0;
          end
          case (op_r)
            ket_pkg::OP_ADD: begin
              state_r <= S_DONE;
              if (full) begin
                status_r <= ket_pkg::ST_FULL;
              end else if (hit_r) begin
                status_r <= ket_pkg::ST_DUPLICATE;
              end else begin
                status_r <= ket_pkg::ST_OK;
                count_r  <= count_r + CNT_W'(1);
              end
            end
            ket_pkg::OP_DELETE: begin
              if (!hit_r) begin
                status_r <= ket_pkg::ST_DEL_MISSING;
                state_r  <= S_DONE;
              end else if (CNT_W'(hit_idx_r) + CNT_W'(1) < count_r) begin
                status_r  <= ket_pkg::ST_OK;
                idx_r     <= CNT_W'(hit_idx_r) + CNT_W'(1);
                cmp_vld_r <= 1'b0;
                state_r   <= S_SHIFT;
              end else begin
                status_r <= ket_pkg::ST_OK;
                count_r  <= count_r - CNT_W'(1);
                state_r  <= S_DONE;
              end
            end
            ket_pkg::OP_LOOKUP: begin
              state_r  <= S_DONE;
              status_r <= hit_r ? ket_pkg::ST_OK : ket_pkg::ST_LKP_MISSING;
            end
            ket_pkg::OP_UPDATE: begin
              state_r <= S_DONE;
              if (taken_r) begin
                status_r <= ket_pkg::ST_KEY_TAKEN;
              end else if (!hit_r) begin
                status_r <= ket_pkg::ST_UPD_MISSING;
              end else begin
                status_r <= ket_pkg::ST_OK;
              end
            end
            ket_pkg::OP_CLEAR: begin
              status_r <= ket_pkg::ST_OK;
              count_r  <= '0;
              state_r  <= S_DONE;
            end
            default: begin
              status_r <= ket_pkg::ST_OK;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_SHIFT: begin
          // read slot i, write it back to slot i-1 in the next cycle
          cmp_vld_r <= issue;
          cmp_idx_r <= IDX_W'(idx_r - CNT_W'(1));
          if (issue) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          if (!issue && !cmp_vld_r) begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_word_r.status      <= status_r;
            out_word_r.found_value <= found_r;
            out_word_r.entry_count <= ket_pkg::COUNT_W'(count_r);
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("entry count beyond depth");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cap_r) <= DEPTH)
    else $error("capacity not saturated");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside completion");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (hit_r && count_r != '0))
    else $error("shift without a matched entry");
`endif

endmodule

`default_nettype wire
